// File: hw/rtl/tacd_pkg.sv
package tacd_pkg;

   localparam int PERIOD_W = 16;
   localparam int DIV_W    = 10;
   localparam int OFS_W    = 8;
   localparam int ADIV_W   = 11;
   localparam int CNT_W    = 11;
   localparam int NUM_OUTS = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 10;

   // one quotient bit per step, numerator is DIV_W bits wide
   localparam int DIV_STEPS = DIV_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [PERIOD_W-1:0] FIRST_PERIOD = 16'd10000;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 16'hFFFF;

   localparam logic [DIV_W-1:0] RST_DIV0 = 10'd0;
   localparam logic [DIV_W-1:0] RST_DIV1 = 10'd64;
   localparam logic [DIV_W-1:0] RST_DIV2 = 10'd32;
   localparam logic [DIV_W-1:0] RST_NUM  = 10'd256;
   localparam logic [OFS_W-1:0] RST_OFS  = 8'd4;

   localparam logic [CSR_IDX_W-1:0] REG_DIV0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIV1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DIV2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NUM  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OFS  = 3'd4;

   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic take;      // input beat accepted this cycle
      logic step;      // one divide iteration
      logic finish;    // update edge counters and load result
   } tacd_cmd_type;

   typedef struct packed {
      logic is_edge;   // offered beat is a rising clock edge
   } tacd_sts_type;

endpackage

// File: hw/rtl/tacd_ctrl.sv
module tacd_ctrl
   import tacd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  tacd_sts_type sts,
   output tacd_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = accept;
            if (accept) begin
               if (sts.is_edge) begin
                  state_in = ST_DIV;
                  step_in  = '0;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("input taken while divide in progress");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff < STEP_W'(DIV_STEPS)))
      else $error("divide step count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   a_edge_divides: assert property (@(posedge clock) disable iff (reset)
      (accept && sts.is_edge) |=> (state_ff == ST_DIV))
      else $error("edge beat did not start divide");

endmodule

// File: hw/rtl/tacd_dp.sv
module tacd_dp
   import tacd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_opcode,
   input  logic                  req_clock_level,
   input  tacd_cmd_type          cmd,
   output tacd_sts_type          sts,
   output logic [NUM_OUTS-1:0]   rsp_out_levels,
   output logic [ADIV_W-1:0]     rsp_adaptive_divisor
);

   logic [DIV_W-1:0]    div0_ff, div1_ff, div2_ff, num_ff;
   logic [OFS_W-1:0]    ofs_ff;

   logic [PERIOD_W-1:0] period_count_ff, period_count_in;
   logic                first_pending_ff, first_pending_in;
   logic                prev_high_ff, prev_high_in;
   logic [CNT_W-1:0]    edge_cnt_ff [NUM_OUTS];
   logic [CNT_W-1:0]    edge_cnt_in [NUM_OUTS];
   logic [NUM_OUTS-1:0] bits_ff, bits_in;
   logic [ADIV_W-1:0]   last_div_ff, last_div_in;

   // divider: remainder and quotient/dividend shift register
   logic [PERIOD_W-1:0] dvsr_ff, dvsr_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [PERIOD_W:0]   rem_shift;
   logic [PERIOD_W:0]   rem_diff;
   logic [PERIOD_W-1:0] period_sel;

   logic [ADIV_W-1:0]   div3;
   logic [ADIV_W-1:0]   thresh [NUM_OUTS];
   logic [CNT_W-1:0]    cnt_inc [NUM_OUTS];
   logic [NUM_OUTS-1:0] wrap;

   logic [NUM_OUTS-1:0] rsp_levels_ff, rsp_levels_in;
   logic [ADIV_W-1:0]   rsp_div_ff, rsp_div_in;

   assign sts.is_edge = (req_opcode == OP_SAMPLE) && req_clock_level && !prev_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         div0_ff <= RST_DIV0;
         div1_ff <= RST_DIV1;
         div2_ff <= RST_DIV2;
         num_ff  <= RST_NUM;
         ofs_ff  <= RST_OFS;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_DIV0: div0_ff <= csr_wdata;
            REG_DIV1: div1_ff <= csr_wdata;
            REG_DIV2: div2_ff <= csr_wdata;
            REG_NUM:  num_ff  <= csr_wdata;
            REG_OFS:  ofs_ff  <= csr_wdata[OFS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      period_sel = first_pending_ff ? FIRST_PERIOD : period_count_ff;
      if (period_sel == '0) begin
         period_sel = PERIOD_W'(1);
      end
   end

   assign rem_shift = {rem_ff, quo_ff[DIV_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dvsr_ff};

   assign div3 = ADIV_W'({1'b0, quo_ff}) + ADIV_W'(ofs_ff);
   assign thresh[0] = ADIV_W'(div0_ff);
   assign thresh[1] = ADIV_W'(div1_ff);
   assign thresh[2] = ADIV_W'(div2_ff);
   assign thresh[3] = div3;

   always_comb begin
      for (int i = 0; i < NUM_OUTS; i++) begin
         cnt_inc[i] = edge_cnt_ff[i] + 1'b1;
         wrap[i]    = cnt_inc[i] > thresh[i];
      end
   end

   always_comb begin
      period_count_in  = period_count_ff;
      first_pending_in = first_pending_ff;
      prev_high_in     = prev_high_ff;
      edge_cnt_in      = edge_cnt_ff;
      bits_in          = bits_ff;
      last_div_in      = last_div_ff;
      dvsr_in          = dvsr_ff;
      rem_in           = rem_ff;
      quo_in           = quo_ff;
      rsp_levels_in    = rsp_levels_ff;
      rsp_div_in       = rsp_div_ff;

      if (cmd.take) begin
         if (req_opcode == OP_TICK) begin
            if (period_count_ff != PERIOD_MAX) begin
               period_count_in = period_count_ff + 1'b1;
            end
         end else if (req_clock_level) begin
            if (!prev_high_ff) begin
               prev_high_in    = 1'b1;
               period_count_in = '0;
               dvsr_in         = period_sel;
               rem_in          = '0;
               quo_in          = num_ff;
            end
            first_pending_in = 1'b0;
         end else begin
            prev_high_in = 1'b0;
         end
         // beats without an edge report the current state
         if (!sts.is_edge) begin
            rsp_levels_in = bits_ff;
            rsp_div_in    = last_div_ff;
         end
      end

      if (cmd.step) begin
         if (!rem_diff[PERIOD_W]) begin
            rem_in = rem_diff[PERIOD_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[PERIOD_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
      end

      if (cmd.finish) begin
         for (int i = 0; i < NUM_OUTS; i++) begin
            edge_cnt_in[i] = wrap[i] ? '0 : cnt_inc[i];
         end
         bits_in       = bits_ff ^ wrap;
         last_div_in   = div3;
         rsp_levels_in = bits_ff ^ wrap;
         rsp_div_in    = div3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_count_ff  <= '0;
         first_pending_ff <= 1'b1;
         prev_high_ff     <= 1'b0;
         for (int i = 0; i < NUM_OUTS; i++) begin
            edge_cnt_ff[i] <= '0;
         end
         bits_ff     <= '0;
         last_div_ff <= '0;
      end else begin
         period_count_ff  <= period_count_in;
         first_pending_ff <= first_pending_in;
         prev_high_ff     <= prev_high_in;
         edge_cnt_ff      <= edge_cnt_in;
         bits_ff          <= bits_in;
         last_div_ff      <= last_div_in;
      end
   end

   always_ff @(posedge clock) begin
      dvsr_ff       <= dvsr_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      rsp_levels_ff <= rsp_levels_in;
      rsp_div_ff    <= rsp_div_in;
   end

   assign rsp_out_levels       = rsp_levels_ff;
   assign rsp_adaptive_divisor = rsp_div_ff;

endmodule

// File: hw/rtl/tempo_adaptive_clock_divider.sv
// Tempo-adaptive clock divider.
// Input channel (req_valid/req_stall): each beat is either a timer tick
// (req_opcode 0) or a sample of the external clock (req_opcode 1, level on
// req_clock_level). Ticks measure the period between rising clock edges.
// Every input beat produces exactly one result beat on rsp_valid/rsp_stall:
// the four divided output levels and the divisor in use for output 3.
// Ticks and samples that are no rising edge need no divide; the result
// is registered and shows the cycle after the input beat, and such beats can
// be taken every cycle while the result channel drains.
// A rising edge runs a restoring divide of the numerator by the measured
// period, one quotient bit per cycle, then updates the edge counters once
// the result channel can take a beat: its result is registered and the next
// input beat is taken no earlier than the cycle in which that result shows.
// The csr_ port writes the divisors, numerator and offset, one per cycle.
// If the receiver stalls, the result register holds and the input is stalled
// until it can take the next result.
// Synchronous reset restores the register defaults, clears all counters and
// output levels, and leaves no result pending.
module tempo_adaptive_clock_divider
   import tacd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic                  req_clock_level,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [NUM_OUTS-1:0]   rsp_out_levels,
   output logic [ADIV_W-1:0]     rsp_adaptive_divisor
);

   tacd_cmd_type cmd;
   tacd_sts_type sts;

   tacd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tacd_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_opcode           (req_opcode),
      .req_clock_level      (req_clock_level),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_out_levels       (rsp_out_levels),
      .rsp_adaptive_divisor (rsp_adaptive_divisor)
   );

endmodule

// File: tb/sv/tb_tempo_adaptive_clock_divider.sv
module tb_tempo_adaptive_clock_divider
   import tacd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic opcode;
      logic level;
      bit   hold;    // wait until every outstanding result has come back
   } clk_beat_type;

   typedef struct {
      logic [NUM_OUTS-1:0] out_levels;
      logic [ADIV_W-1:0]   adaptive_divisor;
   } div_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_opcode = OP_TICK;
   logic                  req_clock_level = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [NUM_OUTS-1:0]   rsp_out_levels;
   logic [ADIV_W-1:0]     rsp_adaptive_divisor;

   clk_beat_type pending_beats[$];
   div_out_type  expected_outs[$];
   int           idle_pct = 0;
   int           stall_pct = 0;
   int           mismatches = 0;

   // shadow of the divider: configuration and state
   logic [DIV_W-1:0]    cfg_div[3] = '{RST_DIV0, RST_DIV1, RST_DIV2};
   logic [DIV_W-1:0]    cfg_num = RST_NUM;
   logic [OFS_W-1:0]    cfg_ofs = RST_OFS;
   logic [PERIOD_W-1:0] tick_count = '0;
   logic                first_pending = 1'b1;
   logic                clk_was_high = 1'b0;
   logic [CNT_W-1:0]    edge_cnt[NUM_OUTS] = '{default: '0};
   logic [NUM_OUTS-1:0] out_bits = '0;
   logic [ADIV_W-1:0]   adiv = '0;

   tempo_adaptive_clock_divider i_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_clock_level      (req_clock_level),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_levels       (rsp_out_levels),
      .rsp_adaptive_divisor (rsp_adaptive_divisor)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic div_out_type divide_step(logic opcode, logic level);
      div_out_type         r;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] sum;
      logic [CNT_W-1:0]    cnt_next;
      logic [CNT_W-1:0]    limit;
      if (opcode == OP_TICK) begin
         if (tick_count != PERIOD_MAX) tick_count++;
      end else if (level) begin
         if (!clk_was_high) begin
            clk_was_high = 1'b1;
            period = first_pending ? FIRST_PERIOD : tick_count;
            tick_count = '0;
            if (period == '0) period = PERIOD_W'(1);
            sum = cfg_num / period + cfg_ofs;
            adiv = sum[ADIV_W-1:0];
            for (int i = 0; i < NUM_OUTS; i++) begin
               limit = (i == NUM_OUTS - 1) ? adiv : CNT_W'(cfg_div[i]);
               cnt_next = edge_cnt[i] + 1'b1;
               if (cnt_next > limit) begin
                  cnt_next = '0;
                  out_bits[i] = ~out_bits[i];
               end
               edge_cnt[i] = cnt_next;
            end
         end
         first_pending = 1'b0;
      end else begin
         clk_was_high = 1'b0;
      end
      r.out_levels = out_bits;
      r.adaptive_divisor = adiv;
      return r;
   endfunction

   always @(posedge clock) begin : drive_req
      clk_beat_type nb;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_outs.push_back(divide_step(req_opcode, req_clock_level));
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() != 0 &&
                !(pending_beats[0].hold && expected_outs.size() != 0) &&
                $urandom_range(99) >= idle_pct) begin
               nb = pending_beats.pop_front();
               req_valid <= 1'b1;
               req_opcode <= nb.opcode;
               req_clock_level <= nb.level;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      div_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outs.size() == 0) begin
            $error("result beat with nothing expected");
            mismatches++;
         end else begin
            want = expected_outs.pop_front();
            if (rsp_out_levels !== want.out_levels) begin
               $error("out_levels: expected %0h, got %0h", want.out_levels, rsp_out_levels);
               mismatches++;
            end
            if (rsp_adaptive_divisor !== want.adaptive_divisor) begin
               $error("adaptive_divisor: expected %0d, got %0d",
                      want.adaptive_divisor, rsp_adaptive_divisor);
               mismatches++;
            end
         end
      end
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   task automatic push_beat(logic opcode, logic level, bit hold = 1'b0);
      clk_beat_type b;
      b.opcode = opcode;
      b.level = level;
      b.hold = hold;
      pending_beats.push_back(b);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_outs.size() != 0);
      // margin before the registers change
      repeat (16) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_DIV0: cfg_div[0] = data;
         REG_DIV1: cfg_div[1] = data;
         REG_DIV2: cfg_div[2] = data;
         REG_NUM:  cfg_num = data;
         REG_OFS:  cfg_ofs = data[OFS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(int d0, int d1, int d2, int num, int ofs);
      csr_write(REG_DIV0, CSR_DATA_W'(d0));
      csr_write(REG_DIV1, CSR_DATA_W'(d1));
      csr_write(REG_DIV2, CSR_DATA_W'(d2));
      csr_write(REG_NUM, CSR_DATA_W'(num));
      csr_write(REG_OFS, CSR_DATA_W'(ofs));
      // writes to unmapped indexes must not land anywhere
      for (int k = REG_OFS + 1; k < 2 ** CSR_IDX_W; k++)
         csr_write(CSR_IDX_W'(k), CSR_DATA_W'($urandom_range(1023)));
   endtask

   function automatic int pick_div();
      return ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(30);
   endfunction

   // mostly clean low/ticks/high clock periods, some noise beats
   task automatic queue_periods(int n_items);
      int added;
      int n_ticks;
      added = 0;
      while (added < n_items) begin
         if ($urandom_range(9) == 0) begin
            push_beat(1'($urandom_range(1)), 1'($urandom_range(1)),
                      $urandom_range(24) == 0);
            added++;
         end else begin
            repeat ($urandom_range(1, 2)) begin
               push_beat(OP_SAMPLE, 1'b0, $urandom_range(24) == 0);
               added++;
            end
            n_ticks = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(6);
            repeat (n_ticks) begin
               push_beat(OP_TICK, 1'($urandom_range(1)));
               added++;
            end
            repeat ($urandom_range(1, 2)) begin
               push_beat(OP_SAMPLE, 1'b1);
               added++;
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, register defaults
      push_beat(OP_TICK, 1'b1);
      push_beat(OP_TICK, 1'b0);
      push_beat(OP_SAMPLE, 1'b0);
      push_beat(OP_SAMPLE, 1'b1);        // first edge uses the fixed period
      push_beat(OP_SAMPLE, 1'b1);        // still high, no edge
      push_beat(OP_SAMPLE, 1'b0);
      push_beat(OP_SAMPLE, 1'b1);        // no ticks since last edge
      push_beat(OP_SAMPLE, 1'b0);
      repeat (3) push_beat(OP_TICK, 1'b1);
      push_beat(OP_SAMPLE, 1'b1);
      push_beat(OP_SAMPLE, 1'b0, 1'b1);
      push_beat(OP_TICK, 1'b0);
      push_beat(OP_SAMPLE, 1'b1);
      push_beat(OP_SAMPLE, 1'b0);
      push_beat(OP_SAMPLE, 1'b0);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         case (p)
            1: set_config(0, 1, 2, 1023, 0);
            2: set_config(1023, 1023, 1023, 0, 255);
            3: set_config(0, 1023, 5, 1, 10'h3FF);
            default: set_config(pick_div(), pick_div(), pick_div(), $urandom_range(1023),
                                ($urandom_range(3) == 0) ? $urandom_range(1023)
                                                         : $urandom_range(20));
         endcase
         @(negedge clock);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 76; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 76; end
            default: begin idle_pct = 26; stall_pct = 26; end
         endcase
         queue_periods(64);
         wait_idle();
      end

      if (expected_outs.size() != 0) begin
         $error("results still expected at end: %0d", expected_outs.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/tacd_pkg.sv
hw/rtl/tacd_ctrl.sv
hw/rtl/tacd_dp.sv
hw/rtl/tempo_adaptive_clock_divider.sv
tb/sv/tb_tempo_adaptive_clock_divider.sv
